[design/sdc_pkg.sv]
// Shared types, codes and the CRC-16/CCITT-FALSE byte step for the serial deframer.
// No dependencies.
`default_nettype none

package sdc_pkg;

   localparam logic [7:0]  StartFirst  = 8'hA5;
   localparam logic [7:0]  StartSecond = 8'h5A;
   localparam logic [15:0] CrcPoly     = 16'h1021;
   localparam logic [15:0] CrcInit     = 16'hFFFF;
   localparam logic [15:0] CrcTop      = 16'h8000;

   localparam logic [7:0]  VersionReset   = 8'd1;
   localparam logic [15:0] MaxLengthReset = 16'd908;

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_FRAME_VERSION      = 2'd0,
      CSR_MAX_PAYLOAD_LENGTH = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_HUNT1   = 3'd0,
      PH_HUNT2   = 3'd1,
      PH_HEADER  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CRC     = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      EV_PAYLOAD  = 2'd0,
      EV_ACCEPT   = 2'd1,
      EV_CRC_BAD  = 2'd2,
      EV_REJECTED = 2'd3
   } event_type;

   typedef struct packed {
      logic [7:0]  frame_version;
      logic [15:0] max_payload_length;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [7:0]  message_type;
      logic [15:0] payload_length;
      logic [15:0] byte_position;
      logic [7:0]  payload_byte;
      logic [15:0] crc_error_total;
      logic [15:0] resync_total;
   } result_type;

   // MSB-first CRC, one byte per call
   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CrcTop) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[design/sdc_csr.sv]
// Configuration registers: frame version and maximum payload length.
// Depends on sdc_pkg.
`default_nettype none

module sdc_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [sdc_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [sdc_pkg::CsrDataWidth-1:0]  csr_wdata,
   output sdc_pkg::cfg_type                       cfg
);
   import sdc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_VERSION:      cfg_in.frame_version      = csr_wdata[7:0];
            CSR_MAX_PAYLOAD_LENGTH: cfg_in.max_payload_length = csr_wdata[15:0];
            default: ; // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_version      <= VersionReset;
         cfg_ff.max_payload_length <= MaxLengthReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[design/sdc_parser.sv]
// Frame parser: start-pair hunt, header capture and check, payload count, CRC verify.
// Depends on sdc_pkg.
`default_nettype none

module sdc_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       data_byte,
   input  wire sdc_pkg::cfg_type cfg,
   output logic                  result_valid,
   output sdc_pkg::result_type   result
);
   import sdc_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [1:0]  hdr_count_ff, hdr_count_in;
   logic [7:0]  version_ff, version_in;
   logic [7:0]  ftype_ff, ftype_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] filled_ff, filled_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic        crc_count_ff, crc_count_in;
   logic [15:0] crc_err_ff, crc_err_in;
   logic [15:0] resync_ff, resync_in;

   logic [15:0] crc_next;
   logic [15:0] filled_inc;
   logic [15:0] len_full;
   event_type   kind;
   logic [15:0] pos;
   logic [7:0]  pbyte;

   assign crc_next   = crc_add(crc_ff, data_byte);
   assign filled_inc = filled_ff + 16'd1;
   assign len_full   = {data_byte, length_ff[7:0]};

   always_comb begin
      phase_in     = phase_ff;
      hdr_count_in = hdr_count_ff;
      version_in   = version_ff;
      ftype_in     = ftype_ff;
      length_in    = length_ff;
      filled_in    = filled_ff;
      crc_in       = crc_ff;
      crc_low_in   = crc_low_ff;
      crc_count_in = crc_count_ff;
      crc_err_in   = crc_err_ff;
      resync_in    = resync_ff;
      result_valid = 1'b0;
      kind         = EV_PAYLOAD;
      pos          = 16'd0;
      pbyte        = 8'd0;

      case (phase_ff)
         PH_HUNT2: begin
            if (data_byte == StartSecond) begin
               phase_in     = PH_HEADER;
               hdr_count_in = 2'd0;
               crc_in       = CrcInit;
            end else if (data_byte != StartFirst) begin
               phase_in = PH_HUNT1;
            end
         end
         PH_HEADER: begin
            crc_in       = crc_next;
            hdr_count_in = hdr_count_ff + 2'd1;
            case (hdr_count_ff)
               2'd0: version_in = data_byte;
               2'd1: ftype_in   = data_byte;
               2'd2: length_in  = {length_ff[15:8], data_byte};
               default: begin
                  length_in    = len_full;
                  hdr_count_in = 2'd0;
                  filled_in    = 16'd0;
                  crc_count_in = 1'b0;
                  if (version_ff != cfg.frame_version ||
                      len_full > cfg.max_payload_length) begin
                     resync_in    = resync_ff + 16'd1;
                     phase_in     = PH_HUNT1;
                     result_valid = 1'b1;
                     kind         = EV_REJECTED;
                  end else begin
                     phase_in = (len_full != 16'd0) ? PH_PAYLOAD : PH_CRC;
                  end
               end
            endcase
         end
         PH_PAYLOAD: begin
            crc_in       = crc_next;
            filled_in    = filled_inc;
            result_valid = 1'b1;
            kind         = EV_PAYLOAD;
            pos          = filled_ff;
            pbyte        = data_byte;
            if (filled_inc >= length_ff) begin
               phase_in     = PH_CRC;
               crc_count_in = 1'b0;
            end
         end
         PH_CRC: begin
            if (!crc_count_ff) begin
               crc_low_in   = data_byte;
               crc_count_in = 1'b1;
            end else begin
               // CRC arrives low byte first
               result_valid = 1'b1;
               kind         = EV_ACCEPT;
               if ({data_byte, crc_low_ff} != crc_ff) begin
                  crc_err_in = crc_err_ff + 16'd1;
                  kind       = EV_CRC_BAD;
               end
               phase_in     = PH_HUNT1;
               hdr_count_in = 2'd0;
               filled_in    = 16'd0;
               crc_count_in = 1'b0;
            end
         end
         default: begin
            phase_in = (data_byte == StartFirst) ? PH_HUNT2 : PH_HUNT1;
         end
      endcase

      result.event_kind      = kind;
      result.message_type    = ftype_in;
      result.payload_length  = length_in;
      result.byte_position   = pos;
      result.payload_byte    = pbyte;
      result.crc_error_total = crc_err_in;
      result.resync_total    = resync_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT1;
         hdr_count_ff <= 2'd0;
         version_ff   <= 8'd0;
         ftype_ff     <= 8'd0;
         length_ff    <= 16'd0;
         filled_ff    <= 16'd0;
         crc_ff       <= CrcInit;
         crc_low_ff   <= 8'd0;
         crc_count_ff <= 1'b0;
         crc_err_ff   <= 16'd0;
         resync_ff    <= 16'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         hdr_count_ff <= hdr_count_in;
         version_ff   <= version_in;
         ftype_ff     <= ftype_in;
         length_ff    <= length_in;
         filled_ff    <= filled_in;
         crc_ff       <= crc_in;
         crc_low_ff   <= crc_low_in;
         crc_count_ff <= crc_count_in;
         crc_err_ff   <= crc_err_in;
         resync_ff    <= resync_in;
      end
   end

endmodule

`default_nettype wire

[design/sdc_out_reg.sv]
// Result register between the parser and the rsp channel; full rate when drained.
// Depends on sdc_pkg.
`default_nettype none

module sdc_out_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire sdc_pkg::result_type in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output sdc_pkg::result_type      out_data
);
   import sdc_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[design/serial_deframer_crc16_check_core.sv]
// Top level of the serial deframer with CRC-16/CCITT-FALSE check.
// Depends on sdc_pkg, sdc_csr, sdc_parser, sdc_out_reg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------
//   req     | in        | req_valid/req_ready  | req_data_byte
//   rsp     | out       | rsp_valid/rsp_ready  | event_kind, message_type, lengths, totals
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One byte per cycle: parser state and CRC update in the cycle a beat is accepted,
// and a resulting event appears on rsp the next cycle from the result register.
// req_ready drops only while the result register is full and rsp_ready is low.
// Synchronous reset returns to hunting the start pair, counters zero, CRC 0xFFFF.
// csr is always ready; writes take effect at the next header check.
`default_nettype none

module serial_deframer_crc16_check_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [7:0]                        req_data_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [1:0]                             rsp_event_kind,
   output logic [7:0]                             rsp_message_type,
   output logic [15:0]                            rsp_payload_length,
   output logic [15:0]                            rsp_byte_position,
   output logic [7:0]                             rsp_payload_byte,
   output logic [15:0]                            rsp_crc_error_total,
   output logic [15:0]                            rsp_resync_total,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [sdc_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [sdc_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import sdc_pkg::*;

   cfg_type    cfg;
   logic       accept;
   logic       result_valid;
   result_type result;
   result_type out_data;

   assign accept = req_valid && req_ready;

   sdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sdc_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .cfg          (cfg),
      .result_valid (result_valid),
      .result       (result)
   );

   sdc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid && result_valid),
      .in_ready  (req_ready),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_event_kind      = out_data.event_kind;
   assign rsp_message_type    = out_data.message_type;
   assign rsp_payload_length  = out_data.payload_length;
   assign rsp_byte_position   = out_data.byte_position;
   assign rsp_payload_byte    = out_data.payload_byte;
   assign rsp_crc_error_total = out_data.crc_error_total;
   assign rsp_resync_total    = out_data.resync_total;

endmodule

`default_nettype wire

[design/sdc_checker.sv]
// Port-level checks for serial_deframer_crc16_check_core, attached by bind.
// Depends on sdc_pkg.
`default_nettype none

module sdc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_event_kind,
   input wire logic [15:0] rsp_payload_length,
   input wire logic [15:0] rsp_byte_position,
   input wire logic [7:0]  rsp_payload_byte
);
   import sdc_pkg::*;

   // stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind) &&
         $stable(rsp_byte_position) && $stable(rsp_payload_byte))
      else $error("rsp beat changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != EV_PAYLOAD |->
         rsp_byte_position == 16'd0 && rsp_payload_byte == 8'd0)
      else $error("verdict beat carries payload fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_PAYLOAD |-> rsp_byte_position < rsp_payload_length)
      else $error("payload byte position beyond header length");

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind serial_deframer_crc16_check_core sdc_checker u_sdc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_event_kind     (rsp_event_kind),
   .rsp_payload_length (rsp_payload_length),
   .rsp_byte_position  (rsp_byte_position),
   .rsp_payload_byte   (rsp_payload_byte)
);

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// Testbench for serial_deframer_crc16_check_core: drives framed byte streams and register
// settings, predicts each result event and checks it beat by beat. Needs sdc_pkg and the core.

module tb;
   import sdc_pkg::*;

   localparam int CycleLimit  = 400000;
   localparam int ReportLimit = 10;
   localparam int RandomItems = 1280;
   localparam int RandomParts = 5;
   localparam logic [CsrIndexWidth-1:0] CsrIndexSpareA = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CsrIndexSpareB = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_data_byte = 8'h00;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [1:0]               rsp_event_kind;
   logic [7:0]               rsp_message_type;
   logic [15:0]              rsp_payload_length;
   logic [15:0]              rsp_byte_position;
   logic [7:0]               rsp_payload_byte;
   logic [15:0]              rsp_crc_error_total;
   logic [15:0]              rsp_resync_total;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   serial_deframer_crc16_check_core uut (.*);

   always #1 clock = ~clock;

   // receiver state as the block should hold it
   phase_type   rx_phase      = PH_HUNT1;
   logic [1:0]  rx_hdr_idx    = '0;
   logic [7:0]  rx_version    = '0;
   logic [7:0]  rx_type       = '0;
   logic [15:0] rx_length     = '0;
   logic [15:0] rx_filled     = '0;
   logic [15:0] rx_crc        = CrcInit;
   logic [7:0]  rx_crc_lo     = '0;
   logic        rx_crc_half   = 1'b0;
   logic [15:0] rx_crc_errors = '0;
   logic [15:0] rx_resyncs    = '0;
   logic [7:0]  cfg_version    = VersionReset;
   logic [15:0] cfg_max_length = MaxLengthReset;
   result_type  pending_events[$];

   logic [15:0] frame_crc = CrcInit;
   int req_idle_pct     = 29;
   int rsp_stall_pct    = 29;
   int items_counted    = 0;
   int settings_written = 0;
   int mismatch_count   = 0;
   int cycle_count      = 0;
   int accepted_frames  = 0;
   int crc_bad_frames   = 0;
   int rejected_headers = 0;
   int payload_beats    = 0;

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ d[i];
         c = {c[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
      end
      return c;
   endfunction

   function automatic result_type frame_event(input event_type kind, input logic [15:0] pos,
                                              input logic [7:0] b);
      result_type r;
      r.event_kind      = kind;
      r.message_type    = rx_type;
      r.payload_length  = rx_length;
      r.byte_position   = pos;
      r.payload_byte    = b;
      r.crc_error_total = rx_crc_errors;
      r.resync_total    = rx_resyncs;
      return r;
   endfunction

   function automatic string event_text(input result_type r);
      return $sformatf("kind %0d type %02h len %0d pos %0d byte %02h crc_err %0d resync %0d",
                       r.event_kind, r.message_type, r.payload_length, r.byte_position,
                       r.payload_byte, r.crc_error_total, r.resync_total);
   endfunction

   task automatic track_byte(input logic [7:0] b);
      logic [15:0] pos;
      event_type   kind;
      items_counted++;
      case (rx_phase)
         PH_HUNT2: begin
            if (b == StartSecond) begin
               rx_phase   = PH_HEADER;
               rx_hdr_idx = '0;
               rx_crc     = CrcInit;
            end else if (b != StartFirst) begin
               rx_phase = PH_HUNT1;
            end
         end
         PH_HEADER: begin
            rx_crc = crc16_step(rx_crc, b);
            case (rx_hdr_idx)
               2'd0:    rx_version = b;
               2'd1:    rx_type = b;
               2'd2:    rx_length[7:0] = b;
               default: rx_length[15:8] = b;
            endcase
            if (rx_hdr_idx == 2'd3) begin
               rx_filled   = '0;
               rx_crc_half = 1'b0;
               if (rx_version != cfg_version || rx_length > cfg_max_length) begin
                  rx_resyncs++;
                  rx_phase = PH_HUNT1;
                  pending_events.push_back(frame_event(EV_REJECTED, 16'h0000, 8'h00));
               end else begin
                  rx_phase = (rx_length != 16'h0000) ? PH_PAYLOAD : PH_CRC;
               end
            end
            rx_hdr_idx++;   // wraps back to zero after the length high byte
         end
         PH_PAYLOAD: begin
            pos = rx_filled;
            rx_crc = crc16_step(rx_crc, b);
            rx_filled++;
            if (rx_filled >= rx_length) begin
               rx_phase    = PH_CRC;
               rx_crc_half = 1'b0;
            end
            pending_events.push_back(frame_event(EV_PAYLOAD, pos, b));
         end
         PH_CRC: begin
            if (!rx_crc_half) begin
               rx_crc_lo   = b;
               rx_crc_half = 1'b1;
            end else begin
               kind = ({b, rx_crc_lo} == rx_crc) ? EV_ACCEPT : EV_CRC_BAD;
               if (kind == EV_CRC_BAD) rx_crc_errors++;
               rx_phase    = PH_HUNT1;
               rx_hdr_idx  = '0;
               rx_filled   = '0;
               rx_crc_half = 1'b0;
               pending_events.push_back(frame_event(kind, 16'h0000, 8'h00));
            end
         end
         default: rx_phase = (b == StartFirst) ? PH_HUNT2 : PH_HUNT1;
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      track_byte(b);
   endtask

   // last = 0 keeps csr_valid up so a following write goes out on the next edge
   task automatic write_register(input logic [CsrIndexWidth-1:0] idx,
                                 input logic [CsrDataWidth-1:0] data, input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (last) csr_valid <= 1'b0;
      case (idx)
         CSR_FRAME_VERSION:      cfg_version = data[7:0];
         CSR_MAX_PAYLOAD_LENGTH: cfg_max_length = data;
         default: ;
      endcase
      settings_written++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic send_framed(input logic [7:0] b);
      frame_crc = crc16_step(frame_crc, b);
      send_byte(b);
   endtask

   task automatic send_frame_check(input logic [15:0] flip);
      logic [15:0] v;
      v = frame_crc ^ flip;
      send_byte(v[7:0]);
      send_byte(v[15:8]);
   endtask

   // payload and check bytes only follow a header the block should take
   task automatic send_frame(input logic [7:0] ver, input logic [7:0] kind,
                             input logic [15:0] len, input logic [15:0] flip);
      logic accepted;
      accepted = (ver == cfg_version) && (len <= cfg_max_length);
      send_byte(StartFirst);
      send_byte(StartSecond);
      frame_crc = CrcInit;
      send_framed(ver);
      send_framed(kind);
      send_framed(len[7:0]);
      send_framed(len[15:8]);
      if (accepted) begin
         for (int i = 0; i < len; i++) send_framed(8'($urandom));
         send_frame_check(flip);
      end
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 4);
      repeat (n) send_byte(($urandom_range(9) < 4) ? StartFirst : 8'($urandom));
   endtask

   // start pair and zero to five further bytes, which may cut the header off
   task automatic send_broken_frame();
      int n;
      n = $urandom_range(0, 5);
      send_byte(StartFirst);
      send_byte(StartSecond);
      for (int i = 0; i < n; i++)
         send_byte((i == 0 && $urandom_range(1) == 1) ? cfg_version : 8'($urandom));
   endtask

   function automatic logic [15:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 3) return 16'($urandom);
      if (r < 8) return cfg_max_length + 16'($urandom_range(1, 3));
      if (r < 11) return 16'($urandom_range(0, (cfg_max_length > 300) ? 300 : cfg_max_length));
      return 16'($urandom_range(0, (cfg_max_length > 12) ? 12 : cfg_max_length));
   endfunction

   task automatic test_directed_frames();
      send_byte(StartSecond);   // lone second start byte while hunting
      send_byte(8'h00);
      send_byte(StartFirst);    // repeated first start byte ahead of the pair
      send_frame(VersionReset, 8'hFF, 16'd0, 16'h0000);
      send_frame(VersionReset, 8'h00, 16'd2, 16'h8001);
      send_frame(8'h00, 8'h5A, 16'd0, 16'h0000);
      wait_idle();
   endtask

   task automatic test_register_settings();
      write_register(CSR_FRAME_VERSION, 16'hFF00, 1'b0);   // upper bits dropped
      write_register(CSR_MAX_PAYLOAD_LENGTH, 16'h0000, 1'b1);
      send_frame(8'h00, 8'h11, 16'd0, 16'h0000);
      send_frame(8'h00, 8'h22, 16'd1, 16'h0000);
      send_frame(VersionReset, 8'h33, 16'd0, 16'h0000);
      wait_idle();
      write_register(CsrIndexSpareA, 16'hFFFF, 1'b0);
      write_register(CsrIndexSpareB, 16'h0001, 1'b1);
      send_frame(8'h00, 8'h44, 16'd0, 16'h0000);
      wait_idle();
      write_register(CSR_FRAME_VERSION, 16'h00FF, 1'b0);
      write_register(CSR_MAX_PAYLOAD_LENGTH, 16'hFFFF, 1'b1);
      send_frame(8'hFF, 8'h55, 16'd300, 16'hFFFF);
      send_frame(8'hFF, 8'h66, 16'd256, 16'h0000);
      wait_idle();
      write_register(CSR_MAX_PAYLOAD_LENGTH, 16'd10, 1'b1);
      send_frame(8'hFF, 8'h77, 16'd10, 16'h0000);
      send_frame(8'hFF, 8'h88, 16'd11, 16'h0000);
      send_frame(8'hFF, 8'h99, 16'hFFFF, 16'h0000);
      // version changes between the type byte and the length check
      send_byte(StartFirst);
      send_byte(StartSecond);
      frame_crc = CrcInit;
      send_framed(8'h07);
      send_framed(8'hAA);
      wait_idle();
      write_register(CSR_FRAME_VERSION, 16'h0007, 1'b1);
      send_framed(8'h02);
      send_framed(8'h00);
      send_framed(8'($urandom));
      send_framed(8'($urandom));
      send_frame_check(16'h0000);
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int          part_end;
      int          r;
      logic [7:0]  ver;
      logic [15:0] max_len;
      for (int part = 0; part < RandomParts; part++) begin
         wait_idle();
         case (part)
            0:       max_len = MaxLengthReset;
            2:       max_len = 16'd908;
            3:       max_len = 16'($urandom_range(0, 40));
            default: max_len = 16'($urandom_range(0, 908));
         endcase
         write_register(CSR_FRAME_VERSION,
                        (part == 0) ? 16'(VersionReset) : 16'($urandom), 1'b0);
         write_register(CSR_MAX_PAYLOAD_LENGTH, max_len, 1'b1);
         // one part runs with no gaps and no stalls
         req_idle_pct  = (part == 2) ? 0 : 29;
         rsp_stall_pct = (part == 2) ? 0 : 29;
         part_end = items_counted + RandomItems / RandomParts;
         while (items_counted < part_end) begin
            r = $urandom_range(99);
            if (r < 75) begin
               ver = ($urandom_range(9) == 0) ? 8'($urandom) : cfg_version;
               send_frame(ver, 8'($urandom), pick_length(),
                          ($urandom_range(4) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000);
            end else if (r < 88) begin
               send_noise();
            end else begin
               send_broken_frame();
            end
         end
      end
      wait_idle();
   endtask

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.event_kind      = rsp_event_kind;
         got.message_type    = rsp_message_type;
         got.payload_length  = rsp_payload_length;
         got.byte_position   = rsp_byte_position;
         got.payload_byte    = rsp_payload_byte;
         got.crc_error_total = rsp_crc_error_total;
         got.resync_total    = rsp_resync_total;
         case (got.event_kind)
            EV_PAYLOAD:  payload_beats++;
            EV_ACCEPT:   accepted_frames++;
            EV_CRC_BAD:  crc_bad_frames++;
            default:     rejected_headers++;
         endcase
         if (pending_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit)
               $display("%0t: unexpected result beat: %s", $realtime, event_text(got));
         end else begin
            want = pending_events.pop_front();
            if (got.event_kind !== want.event_kind || got.message_type !== want.message_type ||
                got.payload_length !== want.payload_length ||
                got.byte_position !== want.byte_position ||
                got.payload_byte !== want.payload_byte ||
                got.crc_error_total !== want.crc_error_total ||
                got.resync_total !== want.resync_total) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit) begin
                  $display("%0t: result mismatch", $realtime);
                  $display("   expected %s", event_text(want));
                  $display("   actual   %s", event_text(got));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_events.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_register_settings();
      test_random_traffic();
      repeat (8) @(posedge clock);
      $display("%0d input beats, %0d register writes, %0d payload beats checked",
               items_counted, settings_written, payload_beats);
      $display("frames: %0d accepted, %0d crc mismatches, %0d headers rejected; %0d mismatches",
               accepted_frames, crc_bad_frames, rejected_headers, mismatch_count);
      if (mismatch_count == 0 && pending_events.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
